// File: src/enacc_pkg.sv
// enacc_pkg: shared constants, command and status types of the error norm accumulator
// used by every module under src; depends on nothing
`default_nettype none

package enacc_pkg;

   // sample and norm formats
   localparam int SAMPLE_WIDTH = 32;
   localparam int NORM_WIDTH = 32;
   localparam int FRAC_BITS = 24;

   // store and run sizes
   localparam int DEFAULT_REFERENCE_DEPTH = 8192;
   localparam int MAX_SAMPLES = 1024;
   localparam int COUNT_WIDTH = $clog2(MAX_SAMPLES + 1);

   // configuration register
   localparam int STEP_WIDTH = 8;
   localparam logic [STEP_WIDTH-1:0] STEP_RESET = 8'd10;

   // accumulator widths
   localparam int ABS_SUM_WIDTH = 42;
   localparam int SUM_WIDTH = 64;
   localparam int SQUARE_WIDTH = SUM_WIDTH - FRAC_BITS;
   localparam int MEAN_SQ_WIDTH = 40;
   localparam int ROOT_WIDTH = SUM_WIDTH / 2;

   // item kinds
   localparam logic KIND_REFERENCE = 1'b0;
   localparam logic KIND_NUMERICAL = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic store_write;
      logic capture;
      logic quot;
      logic rem;
      logic acc;
      logic div_start;
      logic div_square;
      logic take_l1;
      logic take_msq;
      logic root_start;
      logic take_l2;
      logic load_result;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic run_done;
      logic div_done;
      logic root_done;
   } status_type;

endpackage

`default_nettype wire

// File: src/enacc_divider.sv
// enacc_divider: restoring divider, one quotient bit per cycle
// depends on enacc_pkg for the dividend and divisor widths
`default_nettype none

module enacc_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [enacc_pkg::SUM_WIDTH-1:0]   dividend,
   input  wire logic [enacc_pkg::COUNT_WIDTH-1:0] divisor,
   output logic      [enacc_pkg::SUM_WIDTH-1:0]   quotient,
   output logic                                  done
);
   import enacc_pkg::*;

   localparam int CNT_WIDTH = $clog2(SUM_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_ITER = CNT_WIDTH'(SUM_WIDTH - 1);

   logic [SUM_WIDTH-1:0]   work_ff, work_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] divisor_ff;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH:0]   trial;
   logic                   fits;

   // one trial subtraction per cycle
   always_comb begin
      trial = {rem_ff, work_ff[SUM_WIDTH-1]};
      fits = trial >= {1'b0, divisor_ff};
      rem_in = rem_ff;
      work_in = work_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         work_in = dividend;
         count_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = COUNT_WIDTH'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[COUNT_WIDTH-1:0];
         end
         work_in = {work_ff[SUM_WIDTH-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_ITER) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      work_ff <= work_in;
      count_ff <= count_in;
      if (start) begin
         divisor_ff <= divisor;
      end
   end

   assign quotient = work_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// File: src/enacc_sqrt.sv
// enacc_sqrt: digit-by-digit integer square root, two radicand bits per cycle
// depends on enacc_pkg for the radicand and root widths
`default_nettype none

module enacc_sqrt (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [enacc_pkg::SUM_WIDTH-1:0]  radicand,
   output logic      [enacc_pkg::ROOT_WIDTH-1:0] root,
   output logic                                 done
);
   import enacc_pkg::*;

   localparam logic [SUM_WIDTH-1:0] TOP_BIT = {2'b01, {(SUM_WIDTH - 2){1'b0}}};

   logic [SUM_WIDTH-1:0] rest_ff, rest_in;
   logic [SUM_WIDTH-1:0] res_ff, res_in;
   logic [SUM_WIDTH-1:0] bit_ff, bit_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SUM_WIDTH-1:0] trial;

   // one root bit per cycle
   always_comb begin
      trial = res_ff + bit_ff;
      rest_in = rest_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rest_in = radicand;
         res_in = '0;
         bit_in = TOP_BIT;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rest_ff >= trial) begin
            rest_in = rest_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign root = res_ff[ROOT_WIDTH-1:0];
   assign done = done_ff;

endmodule

`default_nettype wire

// File: src/enacc_datapath.sv
// enacc_datapath: reference store, index reduction, difference chain, accumulators,
// divider and square root, result registers; depends on enacc_pkg, enacc_divider, enacc_sqrt
`default_nettype none

module enacc_datapath #(
   parameter int REFERENCE_DEPTH = enacc_pkg::DEFAULT_REFERENCE_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire enacc_pkg::cmd_type                     cmd,
   output enacc_pkg::status_type                       status,
   input  wire logic signed [enacc_pkg::SAMPLE_WIDTH-1:0] req_sample_value,
   input  wire logic                                   req_last,
   input  wire logic                                   csr_write_enable,
   input  wire logic        [enacc_pkg::STEP_WIDTH-1:0] csr_write_data,
   output logic             [enacc_pkg::NORM_WIDTH-1:0] rsp_l1_norm,
   output logic             [enacc_pkg::NORM_WIDTH-1:0] rsp_l2_norm,
   output logic             [enacc_pkg::NORM_WIDTH-1:0] rsp_linf_norm,
   output logic            [enacc_pkg::COUNT_WIDTH-1:0] rsp_sample_count,
   output logic                                        rsp_index_fault
);
   import enacc_pkg::*;

   localparam int ADDR_WIDTH = $clog2(REFERENCE_DEPTH);
   localparam int PROD_WIDTH = COUNT_WIDTH + STEP_WIDTH;
   localparam int PROD2_WIDTH = 2 * PROD_WIDTH;
   localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
   localparam logic [PROD_WIDTH-1:0] DEPTH_P = PROD_WIDTH'(REFERENCE_DEPTH);
   localparam logic [PROD_WIDTH-1:0] RECIP = PROD_WIDTH'((2 ** PROD_WIDTH) / REFERENCE_DEPTH);
   localparam logic [ADDR_WIDTH-1:0] LAST_ADDR = ADDR_WIDTH'(REFERENCE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] LAST_COUNT = COUNT_WIDTH'(MAX_SAMPLES - 1);

   // configuration and load pointer
   logic [STEP_WIDTH-1:0] step_ff;
   logic [ADDR_WIDTH-1:0] ptr_ff, ptr_in;

   // reference store
   logic [SAMPLE_WIDTH-1:0] store [REFERENCE_DEPTH];

   // per-item chain
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                   last_ff;
   logic [PROD_WIDTH-1:0]  product_ff, product_in;
   logic [PROD2_WIDTH-1:0] recip_prod;
   logic [PROD_WIDTH-1:0]  quot_ff, quot_in;
   logic [PROD2_WIDTH-1:0] depth_prod;
   logic [PROD_WIDTH-1:0]  rem_ff, rem_in;
   logic [PROD_WIDTH-1:0]  rem_adj;
   logic [ADDR_WIDTH-1:0]  index;
   logic [SAMPLE_WIDTH-1:0] ref_ff;
   logic [DIFF_WIDTH-1:0]  diff_ff, diff_in;
   logic [DIFF_WIDTH-1:0]  abs_diff;
   logic [SAMPLE_WIDTH-1:0] mag_ff, mag_in;
   logic [SUM_WIDTH-1:0]   full_square;
   logic [SQUARE_WIDTH-1:0] square_ff;

   // run accumulators
   logic [COUNT_WIDTH-1:0]   count_ff;
   logic [ABS_SUM_WIDTH-1:0] abs_sum_ff, abs_sum_in;
   logic [ABS_SUM_WIDTH:0]   abs_total;
   logic [SUM_WIDTH-1:0]     sq_sum_ff, sq_sum_in;
   logic [SUM_WIDTH:0]       sq_total;
   logic [NORM_WIDTH-1:0]    max_ff;
   logic                     fault_ff;

   // end-of-run arithmetic
   logic [SUM_WIDTH-1:0]     dividend;
   logic [SUM_WIDTH-1:0]     quotient;
   logic                     div_done;
   logic [ROOT_WIDTH-1:0]    root;
   logic                     root_done;
   logic [NORM_WIDTH-1:0]    l1_ff, l2_ff;
   logic [MEAN_SQ_WIDTH-1:0] msq_ff;

   // result registers
   logic [NORM_WIDTH-1:0]  l1_out_ff, l2_out_ff, linf_out_ff;
   logic [COUNT_WIDTH-1:0] count_out_ff;
   logic                   fault_out_ff;

   // load pointer advance, wrap at the store end, back to zero on last
   always_comb begin
      if (req_last || ptr_ff == LAST_ADDR) begin
         ptr_in = '0;
      end else begin
         ptr_in = ptr_ff + 1'b1;
      end
   end

   // reference index = count * step, reduced modulo the store depth
   assign product_in = PROD_WIDTH'(count_ff) * PROD_WIDTH'(step_ff);
   assign recip_prod = PROD2_WIDTH'(product_ff) * PROD2_WIDTH'(RECIP);
   assign quot_in = recip_prod[PROD2_WIDTH-1:PROD_WIDTH];
   assign depth_prod = PROD2_WIDTH'(quot_ff) * PROD2_WIDTH'(DEPTH_P);
   assign rem_in = product_ff - depth_prod[PROD_WIDTH-1:0];
   assign rem_adj = (rem_ff >= DEPTH_P) ? (rem_ff - DEPTH_P) : rem_ff;
   assign index = rem_adj[ADDR_WIDTH-1:0];

   // difference, saturated magnitude and truncated square
   assign diff_in = {sample_ff[SAMPLE_WIDTH-1], sample_ff}
                    - {ref_ff[SAMPLE_WIDTH-1], ref_ff};
   assign abs_diff = diff_ff[DIFF_WIDTH-1] ? (DIFF_WIDTH'(0) - diff_ff) : diff_ff;
   assign mag_in = abs_diff[DIFF_WIDTH-1] ? '1 : abs_diff[SAMPLE_WIDTH-1:0];
   assign full_square = SUM_WIDTH'(mag_ff) * SUM_WIDTH'(mag_ff);

   // saturating accumulation
   assign abs_total = {1'b0, abs_sum_ff} + (ABS_SUM_WIDTH + 1)'(mag_ff);
   assign abs_sum_in = abs_total[ABS_SUM_WIDTH] ? '1 : abs_total[ABS_SUM_WIDTH-1:0];
   assign sq_total = {1'b0, sq_sum_ff} + (SUM_WIDTH + 1)'(square_ff);
   assign sq_sum_in = sq_total[SUM_WIDTH] ? '1 : sq_total[SUM_WIDTH-1:0];

   // configuration, pointer and run state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
         ptr_ff <= '0;
         count_ff <= '0;
         abs_sum_ff <= '0;
         sq_sum_ff <= '0;
         max_ff <= '0;
         fault_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            step_ff <= csr_write_data;
         end
         if (cmd.store_write) begin
            ptr_ff <= ptr_in;
         end
         if (cmd.acc) begin
            count_ff <= count_ff + 1'b1;
            abs_sum_ff <= abs_sum_in;
            sq_sum_ff <= sq_sum_in;
            if (mag_ff > max_ff) begin
               max_ff <= mag_ff;
            end
            if (product_ff >= DEPTH_P) begin
               fault_ff <= 1'b1;
            end
         end else if (cmd.load_result) begin
            count_ff <= '0;
            abs_sum_ff <= '0;
            sq_sum_ff <= '0;
            max_ff <= '0;
            fault_ff <= 1'b0;
         end
      end
   end

   // reference store, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.store_write) begin
         store[ptr_ff] <= req_sample_value;
      end
      ref_ff <= store[index];
   end

   // item chain registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_sample_value;
         last_ff <= req_last;
         product_ff <= product_in;
      end
      if (cmd.quot) begin
         quot_ff <= quot_in;
      end
      if (cmd.rem) begin
         rem_ff <= rem_in;
      end
      diff_ff <= diff_in;
      mag_ff <= mag_in;
      square_ff <= full_square[SUM_WIDTH-1:FRAC_BITS];
   end

   // shared divider: mean absolute first, then mean square
   assign dividend = cmd.div_square ? sq_sum_ff : SUM_WIDTH'(abs_sum_ff);

   enacc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (count_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   enacc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand ({msq_ff, FRAC_BITS'(0)}),
      .root     (root),
      .done     (root_done)
   );

   // clamp the quotients and collect the norms
   always_ff @(posedge clock) begin
      if (cmd.take_l1) begin
         l1_ff <= (quotient[SUM_WIDTH-1:NORM_WIDTH] != '0) ? '1
                  : quotient[NORM_WIDTH-1:0];
      end
      if (cmd.take_msq) begin
         msq_ff <= (quotient[SUM_WIDTH-1:MEAN_SQ_WIDTH] != '0) ? '1
                   : quotient[MEAN_SQ_WIDTH-1:0];
      end
      if (cmd.take_l2) begin
         l2_ff <= root;
      end
      if (cmd.load_result) begin
         l1_out_ff <= l1_ff;
         l2_out_ff <= l2_ff;
         linf_out_ff <= max_ff;
         count_out_ff <= count_ff;
         fault_out_ff <= fault_ff;
      end
   end

   assign status.run_done = last_ff || (count_ff == LAST_COUNT);
   assign status.div_done = div_done;
   assign status.root_done = root_done;

   assign rsp_l1_norm = l1_out_ff;
   assign rsp_l2_norm = l2_out_ff;
   assign rsp_linf_norm = linf_out_ff;
   assign rsp_sample_count = count_out_ff;
   assign rsp_index_fault = fault_out_ff;

   // checks
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> count_ff != '0)
      else $error("divider started with a zero sample count");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.rem |=> ({1'b0, rem_ff} < {DEPTH_P, 1'b0}))
      else $error("index remainder needs more than one correction");

endmodule

`default_nettype wire

// File: src/enacc_control.sv
// enacc_control: sequencer for reference loads, sample steps and end-of-run norms
// depends on enacc_pkg for the command and status types
`default_nettype none

module enacc_control (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_kind,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire enacc_pkg::status_type status,
   output enacc_pkg::cmd_type         cmd
);
   import enacc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUOT,
      ST_REM,
      ST_READ,
      ST_DIFF,
      ST_MAG,
      ST_SQR,
      ST_ACC,
      ST_DIVA_GO,
      ST_DIVA_WAIT,
      ST_DIVS_GO,
      ST_DIVS_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_NUMERICAL) begin
                  cmd.capture = 1'b1;
                  state_in = ST_QUOT;
               end else begin
                  cmd.store_write = 1'b1;
               end
            end
         end
         ST_QUOT: begin
            cmd.quot = 1'b1;
            state_in = ST_REM;
         end
         ST_REM: begin
            cmd.rem = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: state_in = ST_DIFF;
         ST_DIFF: state_in = ST_MAG;
         ST_MAG: state_in = ST_SQR;
         ST_SQR: state_in = ST_ACC;
         ST_ACC: begin
            cmd.acc = 1'b1;
            state_in = status.run_done ? ST_DIVA_GO : ST_IDLE;
         end
         ST_DIVA_GO: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIVA_WAIT;
         end
         ST_DIVA_WAIT: begin
            if (status.div_done) begin
               cmd.take_l1 = 1'b1;
               state_in = ST_DIVS_GO;
            end
         end
         ST_DIVS_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_square = 1'b1;
            state_in = ST_DIVS_WAIT;
         end
         ST_DIVS_WAIT: begin
            if (status.div_done) begin
               cmd.take_msq = 1'b1;
               state_in = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: begin
            cmd.root_start = 1'b1;
            state_in = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (status.root_done) begin
               cmd.take_l2 = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.load_result = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register holds a result until taken
   assign rsp_valid_in = cmd.load_result || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // checks
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_DIVA_WAIT || state_ff == ST_DIVS_WAIT))
      else $error("divider finished outside a divide wait");

   a_root_done_expected: assert property (@(posedge clock) disable iff (reset)
      status.root_done |-> state_ff == ST_ROOT_WAIT)
      else $error("square root finished outside its wait");

endmodule

`default_nettype wire

// File: src/error_norm_accumulator.sv
// error_norm_accumulator: top level, joins the controller and the datapath
// depends on enacc_pkg, enacc_control, enacc_datapath
//
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     req_kind, req_sample_value, req_last
// rsp       out        rsp_valid / rsp_stall     rsp_l1_norm, rsp_l2_norm, rsp_linf_norm,
//                                                rsp_sample_count, rsp_index_fault
// csr       in         csr_write_enable          csr_write_data (reference step)
//
// a reference item is written to the store as it is accepted; a numerical item passes
// through the index reduction, store read, difference, magnitude, square and accumulate
// steps while new requests stall; a run end then holds them for the shared divider,
// one quotient bit per cycle for two 64-bit divisions, and the root, one bit per cycle
// reset is synchronous and active high; the store is not cleared
// a stalled result sits in the output register while the next items are taken;
// a later run end waits there until the output register is free
`default_nettype none

module error_norm_accumulator #(
   parameter int REFERENCE_DEPTH = enacc_pkg::DEFAULT_REFERENCE_DEPTH
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic                                      req_kind,
   input  wire logic signed [enacc_pkg::SAMPLE_WIDTH-1:0] req_sample_value,
   input  wire logic                                      req_last,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic             [enacc_pkg::NORM_WIDTH-1:0]   rsp_l1_norm,
   output logic             [enacc_pkg::NORM_WIDTH-1:0]   rsp_l2_norm,
   output logic             [enacc_pkg::NORM_WIDTH-1:0]   rsp_linf_norm,
   output logic             [enacc_pkg::COUNT_WIDTH-1:0]  rsp_sample_count,
   output logic                                           rsp_index_fault,
   input  wire logic                                      csr_write_enable,
   input  wire logic        [enacc_pkg::STEP_WIDTH-1:0]   csr_write_data
);
   import enacc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   enacc_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // store, arithmetic and result registers
   enacc_datapath #(
      .REFERENCE_DEPTH (REFERENCE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample_value (req_sample_value),
      .req_last         (req_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_l1_norm      (rsp_l1_norm),
      .rsp_l2_norm      (rsp_l2_norm),
      .rsp_linf_norm    (rsp_linf_norm),
      .rsp_sample_count (rsp_sample_count),
      .rsp_index_fault  (rsp_index_fault)
   );

endmodule

`default_nettype wire
